FILE: design/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Request codes
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Register indexes on the csr port
   localparam logic CSR_FG_COLOR = 1'b0;
   localparam logic CSR_BG_COLOR = 1'b1;

   // Character codes and reset values
   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [7:0]  BLANK_CODE   = 8'h20;
   localparam logic [15:0] BLANK_RESET  = 16'h0720;
   localparam logic [3:0]  FG_RESET     = 4'd7;
   localparam logic [2:0]  BG_RESET     = 3'd0;
   localparam logic [3:0]  FG_MASK      = 4'b1111;
   localparam logic [2:0]  BG_MASK      = 3'b111;

   typedef struct packed {
      logic        func;
      logic [7:0]  char_code;
      logic [10:0] read_index;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic        scrolled;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic put_en;        // store char / move cursor
      logic read_en;       // launch a cell read
      logic scroll_init;   // load sweep pointers for a scroll
      logic copy_en;       // read one source cell of the scroll copy
      logic fill_en;       // write one fill cell at the sweep pointer
      logic clear_en;      // fill uses the reset blank
      logic rsp_load;      // present a result next cycle
      logic rsp_read;      // result carries the read cell
      logic rsp_scrolled;  // result reports a scroll
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scroll_need;   // the put on the request would scroll
      logic src_last;      // copy source at last cell
      logic dst_last;      // sweep pointer at last cell
      logic rd_pend;       // copied cell waiting to be written
   } stat_type;

endpackage

`default_nettype wire

FILE: design/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_func,
   input  wire tcw_pkg::stat_type  stat,
   output tcw_pkg::cmd_type        cmd,
   output logic                    busy
);
   import tcw_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_COPY  = 5'b01000,
      ST_FILL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.fill_en  = 1'b1;
            cmd.clear_en = 1'b1;
            if (stat.dst_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_func == FUNC_READ) begin
                  cmd.read_en = 1'b1;
                  state_in    = ST_READ;
               end else begin
                  cmd.put_en = 1'b1;
                  if (stat.scroll_need) begin
                     cmd.scroll_init = 1'b1;
                     state_in        = ST_COPY;
                  end else begin
                     cmd.rsp_load = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            cmd.copy_en = 1'b1;
            if (stat.src_last) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_en = 1'b1;
            if (stat.dst_last && !stat.rd_pend) begin
               cmd.rsp_load     = 1'b1;
               cmd.rsp_scrolled = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // A read is answered right after its launch cycle
   a_read_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.read_en |=> (cmd.rsp_load && cmd.rsp_read))
      else $error("read not answered in the following cycle");

   // A scroll copy always runs on into the bottom-row fill
   a_copy_to_fill: assert property (@(posedge clock) disable iff (reset)
      (cmd.copy_en && stat.src_last) |=> (cmd.fill_en && stat.rd_pend))
      else $error("scroll copy did not hand over to the fill");

   // Nothing is accepted while the store is swept
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (cmd.copy_en || cmd.fill_en) |-> (!cmd.put_en && !cmd.read_en))
      else $error("item taken during a sweep");

endmodule

`default_nettype wire

FILE: design/tcw_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tcw_pkg::req_type  req_data,
   input  wire tcw_pkg::cmd_type  cmd,
   output tcw_pkg::stat_type      stat,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [3:0]        csr_wdata,
   output logic                   rsp_valid,
   output tcw_pkg::rsp_type       rsp_data
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
   localparam logic [CW:0]   COL_END   = (CW + 1)'(COLUMNS);

   // Screen store
   logic [15:0] mem [CELL_COUNT];
   logic [15:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [15:0]   wdata;

   // Cursor, row base address, sweep pointers
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic          rd_pend_ff;
   logic          in_range_ff;

   // Color registers
   logic [3:0] fg_ff;
   logic [2:0] bg_ff;

   // Result registers
   logic        rsp_valid_ff;
   logic [15:0] rsp_rdata_ff;
   logic        rsp_scrolled_ff;

   logic          is_nl;
   logic [CW:0]   col_inc;
   logic          row_wrap;
   logic          at_last_row;
   logic [15:0]   idx_wide;
   logic [AW-1:0] idx_addr;
   logic [15:0]   fill_cell;
   logic [7:0]    row_wide;
   logic [7:0]    col_wide;

   // Cursor step for a put
   always_comb begin
      is_nl       = (req_data.char_code == NEWLINE_CODE);
      col_inc     = (CW + 1)'(col_ff) + (CW + 1)'(1);
      row_wrap    = is_nl || (col_inc == COL_END);
      at_last_row = (row_ff == LAST_ROW);
   end

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      base_in = base_ff;
      if (cmd.put_en) begin
         if (row_wrap) begin
            col_in = '0;
            if (!at_last_row) begin
               row_in  = row_ff + RW'(1);
               base_in = base_ff + ROW_STEP;
            end
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   // Write port: char store, copied cell, or fill blank
   assign fill_cell = cmd.clear_en ? BLANK_RESET : {1'b0, bg_ff, fg_ff, BLANK_CODE};

   always_comb begin
      we     = 1'b0;
      waddr  = dst_ff;
      wdata  = fill_cell;
      dst_in = dst_ff;
      src_in = src_ff;
      priority if (cmd.put_en && !is_nl) begin
         we    = 1'b1;
         waddr = base_ff + AW'(col_ff);
         wdata = {1'b0, bg_ff, fg_ff, req_data.char_code};
      end else if (rd_pend_ff) begin
         we     = 1'b1;
         wdata  = rdata_ff;
         dst_in = dst_ff + AW'(1);
      end else if (cmd.fill_en) begin
         we     = 1'b1;
         dst_in = dst_ff + AW'(1);
      end else begin
         we = 1'b0;
      end
      if (cmd.scroll_init) begin
         src_in = ROW_STEP;
         dst_in = '0;
      end else if (cmd.copy_en) begin
         src_in = src_ff + AW'(1);
      end
   end

   // Read port: scroll source or requested cell
   assign idx_wide = 16'(req_data.read_index);
   assign idx_addr = idx_wide[AW-1:0];
   assign raddr    = cmd.copy_en ? src_ff : idx_addr;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         rd_pend_ff   <= cmd.copy_en;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_ff <= csr_wdata & FG_MASK;
            CSR_BG_COLOR: bg_ff <= csr_wdata[2:0] & BG_MASK;
            default:      fg_ff <= fg_ff;
         endcase
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         in_range_ff <= (32'(req_data.read_index) < 32'(CELL_COUNT));
      end
      if (cmd.rsp_load) begin
         rsp_rdata_ff    <= (cmd.rsp_read && in_range_ff) ? rdata_ff : 16'd0;
         rsp_scrolled_ff <= cmd.rsp_scrolled;
      end
   end

   assign row_wide = 8'(row_ff);
   assign col_wide = 8'(col_ff);

   always_comb begin
      rsp_data.read_data  = rsp_rdata_ff;
      rsp_data.cursor_row = row_wide[4:0];
      rsp_data.cursor_col = col_wide[6:0];
      rsp_data.scrolled   = rsp_scrolled_ff;
   end
   assign rsp_valid = rsp_valid_ff;

   // Status
   always_comb begin
      stat.scroll_need = row_wrap && at_last_row;
      stat.src_last    = (src_ff == LAST_CELL);
      stat.dst_last    = (dst_ff == LAST_CELL);
      stat.rd_pend     = rd_pend_ff;
   end

   // A put never shares the write port with a sweep write
   a_port_free: assert property (@(posedge clock) disable iff (reset)
      cmd.put_en |-> (!rd_pend_ff && !cmd.fill_en))
      else $error("put collides with sweep write");

   // Cursor stays on screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS))
      else $error("cursor off screen");

   // Row base tracks the cursor row
   a_base_match: assert property (@(posedge clock) disable iff (reset)
      cmd.put_en |-> (32'(base_ff) == 32'(row_ff) * COLUMNS))
      else $error("row base out of step with cursor row");

endmodule

`default_nettype wire

FILE: design/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Text console: a ROWS x COLUMNS store of 16-bit cells (char low byte,
// attribute high byte) with a write cursor.
// Requests: drive req_data and raise start; the item is taken on an edge with
// start high and busy low. func put stores char_code at the cursor (newline
// moves to the next row), func read fetches cell read_index.
// Results: rsp_valid pulses for one cycle with rsp_data; it cannot be held
// off, so capture it on that cycle. Every item gives exactly one result.
// Timing: a put without scroll loads the result register in its acceptance cycle
// and the next item may follow at once; a read first passes the store's
// registered read port (its launch cycle), then the result register.
// A put that runs off the bottom row scrolls: the store's read port and write
// port together copy ROWS*COLUMNS-COLUMNS cells, one per cycle, then fill the
// bottom row before the result is given. Reset: the store is swept to blank
// light grey, one cell a cycle, with busy high; the cursor goes home. Colors are
// written through csr_we/csr_index/csr_wdata only while no item is in flight;
// the user must keep to this, as the block itself does not enforce it.
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tcw_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output tcw_pkg::rsp_type       rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [3:0]        csr_wdata
);
   import tcw_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tcw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_data.func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   tcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_FG_COLOR;
   logic [3:0] csr_wdata = '0;

   text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the screen, cursor and colors
   logic [15:0] screen_img [0:CELLS-1];
   int unsigned cur_row;
   int unsigned cur_col;
   logic [3:0]  fg_now;
   logic [2:0]  bg_now;

   req_type     text_items[$];
   rsp_type     awaited_reports[$];
   bit          gaps_on;
   int unsigned gap_left;
   int unsigned mismatch_count;

   function automatic logic [7:0] attr_now();
      return {1'b0, bg_now, fg_now};
   endfunction

   // Cursor to the next row; scroll the screen when it runs off the bottom
   function automatic logic advance_row();
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS)
         return 1'b0;
      cur_row = ROWS - 1;
      for (int i = 0; i < CELLS - COLUMNS; i++)
         screen_img[i] = screen_img[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++)
         screen_img[i] = {attr_now(), BLANK_CODE};
      return 1'b1;
   endfunction

   // Apply one item to the shadow console and return the report it gives
   function automatic rsp_type apply_console_item(input req_type r);
      rsp_type res;
      res = '0;
      if (r.func == FUNC_READ) begin
         if (r.read_index < CELLS)
            res.read_data = screen_img[r.read_index];
      end else if (r.char_code == NEWLINE_CODE) begin
         res.scrolled = advance_row();
      end else begin
         screen_img[cur_row * COLUMNS + cur_col] = {attr_now(), r.char_code};
         cur_col++;
         if (cur_col >= COLUMNS)
            res.scrolled = advance_row();
      end
      res.cursor_row = 5'(cur_row);
      res.cursor_col = 7'(cur_col);
      return res;
   endfunction

   // Item driver: start stays up across back-to-back items
   always @(posedge clock) begin : item_driver
      logic taken;
      taken = start && !busy;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (taken) begin
            awaited_reports.push_back(apply_console_item(req_data));
            if (gaps_on && $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 7);
         end
         if (!start || taken) begin
            if (gap_left != 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (text_items.size() != 0) begin
               start <= 1'b1;
               req_data <= text_items.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Report monitor: every strobe is matched against the oldest expectation
   always @(posedge clock) begin : report_monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t ns: report with nothing pending, expected none, got %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = awaited_reports.pop_front();
            check_field("read_data", want.read_data, rsp_data.read_data);
            check_field("cursor_row", 16'(want.cursor_row), 16'(rsp_data.cursor_row));
            check_field("cursor_col", 16'(want.cursor_col), 16'(rsp_data.cursor_col));
            check_field("scrolled", 16'(want.scrolled), 16'(rsp_data.scrolled));
         end
      end
   end

   function automatic req_type make_item(input logic f, input logic [7:0] code,
                                         input logic [10:0] idx);
      req_type r;
      r.func = f;
      r.char_code = code;
      r.read_index = idx;
      return r;
   endfunction

   // Reads lean toward the bottom rows, where scrolls leave their marks
   function automatic logic [10:0] pick_index();
      case ($urandom_range(0, 9))
         0, 1:    return 11'($urandom_range(0, 2047));
         2, 3, 4: return 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
         default: return 11'($urandom_range(0, CELLS - 1));
      endcase
   endfunction

   // Lines of random text ending in newline, with reads mixed in
   task automatic queue_text(input int unsigned n);
      int unsigned made;
      int unsigned len;
      made = 0;
      while (made < n) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(76, 90) : $urandom_range(0, 30);
         for (int unsigned k = 0; k < len && made < n; k++) begin
            text_items.push_back(make_item(FUNC_PUT, 8'($urandom_range(0, 255)),
                                           11'($urandom_range(0, 2047))));
            made++;
            if ($urandom_range(0, 3) == 0 && made < n) begin
               text_items.push_back(make_item(FUNC_READ, 8'($urandom_range(0, 255)),
                                              pick_index()));
               made++;
            end
         end
         if (made < n) begin
            text_items.push_back(make_item(FUNC_PUT, NEWLINE_CODE,
                                           11'($urandom_range(0, 2047))));
            made++;
         end
      end
   endtask

   // Block idle: nothing queued, nothing in flight, nothing awaited
   task automatic wait_drained();
      do
         @(negedge clock);
      while (text_items.size() != 0 || start || awaited_reports.size() != 0 || busy);
   endtask

   task automatic write_color(input logic idx, input logic [3:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FG_COLOR)
         fg_now = value & FG_MASK;
      else
         bg_now = value[2:0] & BG_MASK;
   endtask

   task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg, input bit gaps);
      wait_drained();
      write_color(CSR_FG_COLOR, fg);
      write_color(CSR_BG_COLOR, bg);
      gaps_on = gaps;
   endtask

   initial begin
      for (int i = 0; i < CELLS; i++)
         screen_img[i] = BLANK_RESET;
      cur_row = 0;
      cur_col = 0;
      fg_now = FG_RESET;
      bg_now = BG_RESET;
      gaps_on = 1'b0;
      mismatch_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Default colors; extreme bytes, reads at and past the end of the store
      set_colors(FG_RESET, 4'(BG_RESET), 1'b1);
      text_items.push_back(make_item(FUNC_PUT, 8'h00, 11'h7ff));
      text_items.push_back(make_item(FUNC_PUT, 8'hff, 11'h000));
      text_items.push_back(make_item(FUNC_READ, 8'hff, 11'd0));
      text_items.push_back(make_item(FUNC_READ, 8'h00, 11'd1));
      text_items.push_back(make_item(FUNC_READ, 8'h00, 11'd2));
      text_items.push_back(make_item(FUNC_READ, 8'h00, 11'(CELLS - 1)));
      text_items.push_back(make_item(FUNC_READ, 8'h00, 11'(CELLS)));
      text_items.push_back(make_item(FUNC_READ, 8'h00, 11'h7ff));
      text_items.push_back(make_item(FUNC_PUT, NEWLINE_CODE, 11'd0));
      queue_text(300);

      // Brightest colors, bg written with its unused bit set; newline on the last row
      set_colors(4'hf, 4'hf, 1'b1);
      for (int unsigned r = cur_row; r < ROWS - 1; r++)
         text_items.push_back(make_item(FUNC_PUT, NEWLINE_CODE, 11'd0));
      text_items.push_back(make_item(FUNC_PUT, NEWLINE_CODE, 11'd0));
      text_items.push_back(make_item(FUNC_READ, 8'h00, 11'(CELLS - COLUMNS)));
      text_items.push_back(make_item(FUNC_READ, 8'h00, 11'(CELLS - COLUMNS - 1)));
      queue_text(300);

      // Black on black, no idling
      set_colors(4'h0, 4'h0, 1'b0);
      queue_text(300);

      set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1);
      queue_text(350);

      // Last stretch runs without idling
      set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 7)), 1'b0);
      queue_text(300);

      wait_drained();
      repeat (CELLS + 100) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog: every item scrolling and idling would still finish well inside this
   initial begin
      #80_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
